// File: design/cplt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cplt_pkg;

    localparam int NUM_PACKS_DEF    = 8;
    localparam int SERIAL_BYTES_DEF = 32;
    localparam int POS_W            = 7;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [10:0] TX_BASE       = 11'h600;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_SYNC  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    localparam logic [3:0] FN_PDO1 = 4'h3;
    localparam logic [3:0] FN_PDO2 = 4'h5;
    localparam logic [3:0] FN_PDO3 = 4'h7;
    localparam logic [3:0] FN_PDO4 = 4'h9;
    localparam logic [3:0] FN_SDO  = 4'hC;

    localparam logic [0:8][7:0] DEFAULT_TEXT = {
        8'h53, 8'h42, 8'h50, 8'h5F, 8'h54, 8'h45, 8'h53, 8'h54, 8'h32
    };

    typedef enum logic [1:0] {
        LINK_DOWN = 2'd0,
        LINK_AUTH = 2'd1,
        LINK_UP   = 2'd2
    } t_link;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_BYTES,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_link              link;
        logic               pending;
        logic [31:0]        deadline;
        logic [POS_W-1:0]   wpos;
        logic [19:0]        voltage;
        logic signed [19:0] current;
        logic [7:0]         charge;
        logic [7:0]         mode;
        logic [15:0]        status;
        logic [15:0][7:0]   cells;
        logic [7:0][7:0]    temps;
    } t_rec;

    localparam t_rec REC_RESET = '{
        link:     LINK_DOWN,
        pending:  1'b0,
        deadline: 32'd0,
        wpos:     '0,
        voltage:  20'd0,
        current:  20'sd0,
        charge:   8'd0,
        mode:     8'd0,
        status:   16'd0,
        cells:    {16{8'h20}},
        temps:    {8{8'h19}}
    };

    typedef struct packed {
        logic               tx_valid;
        logic [10:0]        tx_id;
        logic               tx_length;
        logic               pack_touched;
        logic [2:0]         pack_number;
        logic [1:0]         link_state;
        logic [19:0]        pack_voltage;
        logic signed [19:0] pack_current;
        logic [7:0]         charge_percent;
        logic [7:0]         pack_mode;
        logic [15:0]        status_bits;
    } t_res;

endpackage

`default_nettype wire

// File: design/can_pack_link_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                         Carries
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   frame, sync request or timeout check
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   one result per input item
// cfg       in   i_cfg_valid/o_cfg_ready           reply_timeout_ms
//
// An item passes through four steps (accept, record read, update, result load), plus
// one serial byte step for each byte of an SDO reply, up to 8, or SERIAL_BYTES steps when a sync
// request clears the serial store, since the serial memory port writes a single byte at a time.
// After reset a pass over all NUM_PACKS*SERIAL_BYTES entries loads the serial memory;
// no item is accepted meanwhile. A new item is taken while a result waits on m_axis.

module can_pack_link_tracker #(
    parameter int NUM_PACKS    = cplt_pkg::NUM_PACKS_DEF,
    parameter int SERIAL_BYTES = cplt_pkg::SERIAL_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // frame_id, frame_length, frame_data, pack_index, now_ms, zero pad
    input  wire logic [119:0] i_s_axis_tdata,
    // kind
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tx_id, tx_length, pack_touched, pack_number, link_state, pack_voltage,
    // pack_current, charge_percent, pack_mode, status_bits, zero pad
    output logic [95:0]       o_m_axis_tdata,
    // tx_valid
    output logic [0:0]        o_m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data
);
    import cplt_pkg::*;

    localparam int PW        = (NUM_PACKS > 1) ? $clog2(NUM_PACKS) : 1;
    localparam int SER_DEPTH = NUM_PACKS * SERIAL_BYTES;
    localparam int SAW       = $clog2(SER_DEPTH);

    t_state r_state, n_state;

    logic [15:0]      r_timeout;
    logic [1:0]       r_kind;
    logic [3:0]       r_len;
    logic [63:0]      r_data;
    logic [31:0]      r_now;
    logic [PW-1:0]    r_addr;
    logic [2:0]       r_pnum;
    logic             r_hit;
    logic [3:0]       r_func;

    t_rec             r_rec_mem [NUM_PACKS];
    t_rec             r_rec_q;
    logic             r_rec_vld;
    logic [NUM_PACKS-1:0] r_vld_bits;

    logic [7:0]       r_ser_mem [SER_DEPTH];
    logic [SAW-1:0]   r_icnt;
    logic [POS_W-1:0] r_ioff;
    logic [SAW-1:0]   r_sbase;
    logic [POS_W-1:0] r_bleft;
    logic [POS_W-1:0] r_bpos;
    logic             r_bclr;

    t_res             r_res;
    t_res             r_out;
    logic             r_out_valid;

    logic [10:0]      in_id;
    logic [3:0]       in_len;
    logic [63:0]      in_data;
    logic [2:0]       in_pack;
    logic [31:0]      in_now;
    logic [6:0]       in_node;
    logic [3:0]       in_func;
    logic             in_node_ok;
    logic             in_func_ok;
    logic             in_hit;
    logic [PW-1:0]    in_addr;
    logic [2:0]       in_pnum;
    logic             accept;

    t_rec             rec_cur;
    t_rec             n_rec;
    t_res             calc_res;
    logic [POS_W-1:0] calc_bleft;
    logic [POS_W-1:0] calc_bpos;
    logic             calc_bclr;
    logic [3:0]       sdo_n;
    logic [POS_W-1:0] pos_sum;
    logic signed [19:0] cur_ext;

    logic             rec_we;
    logic             out_load;
    logic             ser_we;
    logic [SAW-1:0]   ser_addr;
    logic [7:0]       ser_data;

    assign in_id   = i_s_axis_tdata[10:0];
    assign in_len  = i_s_axis_tdata[14:11];
    assign in_data = i_s_axis_tdata[78:15];
    assign in_pack = i_s_axis_tdata[81:79];
    assign in_now  = i_s_axis_tdata[113:82];
    assign in_node = in_id[6:0];
    assign in_func = in_id[10:7];

    assign in_node_ok = (in_node != 7'd0) && (32'(in_node) <= 32'(NUM_PACKS));
    assign in_func_ok = (in_func == FN_PDO1) || (in_func == FN_PDO2) ||
                        (in_func == FN_PDO3) || (in_func == FN_PDO4) ||
                        (in_func == FN_SDO);

    always_comb begin
        in_hit  = 1'b0;
        in_addr = PW'(in_pack);
        in_pnum = in_pack;
        case (i_s_axis_tuser)
            KIND_FRAME: begin
                in_hit  = in_node_ok && in_func_ok;
                in_addr = PW'(in_node - 7'd1);
                in_pnum = in_node[2:0] - 3'd1;
            end
            KIND_SYNC, KIND_CHECK: begin
                in_hit = 32'(in_pack) < 32'(NUM_PACKS);
            end
            default: in_hit = 1'b0;
        endcase
    end

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_icnt == SAW'(SER_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_READ;
            end
            ST_READ: n_state = ST_CALC;
            ST_CALC: begin
                n_state = (calc_bleft != '0) ? ST_BYTES : ST_DONE;
            end
            ST_BYTES: begin
                if (r_bleft == POS_W'(1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        rec_we          = (r_state == ST_CALC) && r_hit;
        out_load        = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
        ser_we          = 1'b0;
        ser_addr        = r_icnt;
        ser_data        = 8'd0;
        case (r_state)
            ST_INIT: begin
                ser_we = 1'b1;
                if (r_ioff < POS_W'(9)) ser_data = DEFAULT_TEXT[r_ioff[3:0]];
            end
            ST_BYTES: begin
                ser_we   = r_bpos < POS_W'(SERIAL_BYTES);
                ser_addr = r_sbase + SAW'(r_bpos);
                ser_data = r_bclr ? 8'd0 : r_data[7:0];
            end
            default: ser_we = 1'b0;
        endcase
    end

    always_comb begin
        rec_cur    = r_rec_vld ? r_rec_q : REC_RESET;
        n_rec      = rec_cur;
        calc_res   = '0;
        calc_bleft = '0;
        calc_bpos  = '0;
        calc_bclr  = 1'b0;
        sdo_n      = (r_len > 4'd8) ? 4'd8 : r_len;
        pos_sum    = rec_cur.wpos + POS_W'(sdo_n);
        cur_ext    = {{4{r_data[31]}}, r_data[31:16]};
        case (r_kind)
            KIND_FRAME: begin
                if (r_hit && r_func == FN_SDO) begin
                    calc_bleft = POS_W'(sdo_n);
                    calc_bpos  = rec_cur.wpos;
                    if (r_len < 4'd8) begin
                        n_rec.link = LINK_UP;
                    end else begin
                        n_rec.link = LINK_AUTH;
                        n_rec.wpos = (pos_sum > POS_W'(SERIAL_BYTES)) ?
                                     POS_W'(SERIAL_BYTES) : pos_sum;
                    end
                    n_rec.pending         = 1'b0;
                    calc_res.pack_touched = 1'b1;
                end else if (r_hit && rec_cur.link == LINK_UP) begin
                    case (r_func)
                        FN_PDO1: begin
                            n_rec.voltage = ({4'd0, r_data[15:0]} << 3) +
                                            ({4'd0, r_data[15:0]} << 1);
                            n_rec.current = (cur_ext <<< 3) + (cur_ext <<< 1);
                            n_rec.charge  = r_data[39:32];
                            n_rec.mode    = r_data[47:40];
                            n_rec.status  = r_data[63:48];
                        end
                        FN_PDO2: n_rec.cells[7:0]  = r_data;
                        FN_PDO3: n_rec.cells[15:8] = r_data;
                        default: n_rec.temps       = r_data;
                    endcase
                    calc_res.pack_touched = 1'b1;
                end
            end
            KIND_SYNC: begin
                if (r_hit && !rec_cur.pending) begin
                    if (rec_cur.link == LINK_DOWN) begin
                        n_rec.wpos         = '0;
                        calc_bleft         = POS_W'(SERIAL_BYTES);
                        calc_bclr          = 1'b1;
                        calc_res.tx_length = 1'b0;
                    end else begin
                        calc_res.tx_length = 1'b1;
                    end
                    calc_res.tx_valid     = 1'b1;
                    calc_res.tx_id        = TX_BASE + 11'(r_addr) + 11'd1;
                    n_rec.pending         = 1'b1;
                    n_rec.deadline        = r_now + {16'd0, r_timeout};
                    n_rec.link            = LINK_AUTH;
                    calc_res.pack_touched = 1'b1;
                end
            end
            KIND_CHECK: begin
                if (r_hit && rec_cur.pending && rec_cur.deadline < r_now) begin
                    n_rec.pending         = 1'b0;
                    n_rec.link            = LINK_DOWN;
                    calc_res.pack_touched = 1'b1;
                end
            end
            default: calc_res = '0;
        endcase
        if (r_hit) begin
            calc_res.pack_number    = r_pnum;
            calc_res.link_state     = n_rec.link;
            calc_res.pack_voltage   = n_rec.voltage;
            calc_res.pack_current   = n_rec.current;
            calc_res.charge_percent = n_rec.charge;
            calc_res.pack_mode      = n_rec.mode;
            calc_res.status_bits    = n_rec.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_timeout   <= TIMEOUT_RESET;
            r_vld_bits  <= '0;
            r_out_valid <= 1'b0;
            r_icnt      <= '0;
            r_ioff      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_timeout <= i_cfg_data;
            if (rec_we) r_vld_bits[r_addr] <= 1'b1;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_INIT) begin
                r_icnt <= r_icnt + SAW'(1);
                r_ioff <= (r_ioff == POS_W'(SERIAL_BYTES - 1)) ? '0 : r_ioff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_s_axis_tuser;
            r_len  <= in_len;
            r_data <= in_data;
            r_now  <= in_now;
            r_addr <= in_addr;
            r_pnum <= in_pnum;
            r_hit  <= in_hit;
            r_func <= in_func;
        end
        if (r_state == ST_READ) r_rec_vld <= r_vld_bits[r_addr];
        if (r_state == ST_CALC) begin
            r_res   <= calc_res;
            r_bleft <= calc_bleft;
            r_bpos  <= calc_bpos;
            r_bclr  <= calc_bclr;
            r_sbase <= SAW'(r_addr * SERIAL_BYTES);
        end
        if (r_state == ST_BYTES) begin
            r_bleft <= r_bleft - POS_W'(1);
            r_bpos  <= r_bpos + POS_W'(1);
            r_data  <= {8'd0, r_data[63:8]};
        end
        if (out_load) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) r_rec_mem[r_addr] <= n_rec;
        r_rec_q <= r_rec_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ser_we) r_ser_mem[ser_addr] <= ser_data;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.tx_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.status_bits, r_out.pack_mode, r_out.charge_percent,
                              r_out.pack_current, r_out.pack_voltage, r_out.link_state,
                              r_out.pack_number, r_out.pack_touched, r_out.tx_length,
                              r_out.tx_id};

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_s_axis_tready)
        else $error("item accepted during serial memory load");

    a_pending_auth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rec_we && n_rec.pending) |-> (n_rec.link == LINK_AUTH))
        else $error("pending pack not in authorizing state");

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_we |-> (n_rec.wpos <= POS_W'(SERIAL_BYTES)))
        else $error("serial write position beyond store");

    a_tx_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_valid) |->
            (r_out.pack_touched && r_out.tx_id[10:7] == FN_SDO))
        else $error("request frame without record change or with wrong id");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_READ))
        else $error("accepted transaction did not start a record read");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cplt_pkg::*;

    localparam int NPACK         = NUM_PACKS_DEF;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_LINES     = 40;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [3:0] FN_UNUSED  = 4'hE;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [2:0]  pidx;
        logic [31:0] now;
    } t_item;

    typedef struct {
        t_item s;
        bit    typed;
        t_res  want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [95:0]  o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data;

    can_pack_link_tracker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    t_link              link_q   [NPACK];
    logic               awaiting [NPACK];
    logic [31:0]        due_ms   [NPACK];
    logic [19:0]        volt     [NPACK];
    logic signed [19:0] amps     [NPACK];
    logic [7:0]         soc      [NPACK];
    logic [7:0]         mode_b   [NPACK];
    logic [15:0]        stat     [NPACK];
    logic [15:0]        timeout_ms;

    t_res        reports_due [$];
    t_row        rows [$];
    logic [31:0] clock_ms;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          hold_left;
    int          errors;
    int          items_sent;
    int          live_items;
    int          reports_seen;
    int          timeouts_fired;
    int          pdo_updates;
    int          cycles;
    logic [15:0] last_timeout;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: timeout after %0d cycles", cycles);
        $display("tb_top: errors");
        $finish;
    end

    function automatic void reset_tracker();
        for (int p = 0; p < NPACK; p++) begin
            link_q[p]   = LINK_DOWN;
            awaiting[p] = 1'b0;
            due_ms[p]   = '0;
            volt[p]     = '0;
            amps[p]     = '0;
            soc[p]      = '0;
            mode_b[p]   = '0;
            stat[p]     = '0;
        end
        timeout_ms = TIMEOUT_RESET;
    endfunction

    function automatic t_res pack_view(int p);
        t_res r;
        r                = '0;
        r.pack_number    = 3'(p);
        r.link_state     = link_q[p];
        r.pack_voltage   = volt[p];
        r.pack_current   = amps[p];
        r.charge_percent = soc[p];
        r.pack_mode      = mode_b[p];
        r.status_bits    = stat[p];
        return r;
    endfunction

    function automatic t_res track_item(t_item it);
        t_res       r;
        int         p;
        int         s;
        logic [3:0] fn;
        logic [6:0] node;
        bit         fire;
        bit         keep;
        bit         touched;
        r       = '0;
        fire    = 1'b0;
        keep    = 1'b0;
        touched = 1'b0;
        p       = int'(it.pidx);
        case (it.kind)
            KIND_FRAME: begin
                node = it.id[6:0];
                fn   = it.id[10:7];
                if (node != 7'd0 && int'(node) <= NPACK) begin
                    p = int'(node) - 1;
                    if (fn inside {FN_PDO1, FN_PDO2, FN_PDO3, FN_PDO4}) begin
                        if (link_q[p] == LINK_UP) begin
                            if (fn == FN_PDO1) begin
                                s         = $signed(it.data[31:16]);
                                volt[p]   = 20'(10 * int'(it.data[15:0]));
                                amps[p]   = 20'(10 * s);
                                soc[p]    = it.data[39:32];
                                mode_b[p] = it.data[47:40];
                                stat[p]   = it.data[63:48];
                            end
                            touched = 1'b1;
                            pdo_updates++;
                        end
                        r = pack_view(p);
                        r.pack_touched = touched;
                    end else if (fn == FN_SDO) begin
                        link_q[p]   = (it.len < 4'd8) ? LINK_UP : LINK_AUTH;
                        awaiting[p] = 1'b0;
                        r = pack_view(p);
                        r.pack_touched = 1'b1;
                    end
                end
            end
            KIND_SYNC: begin
                if (!awaiting[p]) begin
                    fire        = 1'b1;
                    keep        = (link_q[p] != LINK_DOWN);
                    awaiting[p] = 1'b1;
                    due_ms[p]   = it.now + {16'd0, timeout_ms};
                    link_q[p]   = LINK_AUTH;
                end
                r = pack_view(p);
                r.tx_valid     = fire;
                r.tx_id        = fire ? 11'(TX_BASE + 11'(p + 1)) : 11'd0;
                r.tx_length    = fire & keep;
                r.pack_touched = fire;
            end
            KIND_CHECK: begin
                if (awaiting[p] && due_ms[p] < it.now) begin
                    awaiting[p] = 1'b0;
                    link_q[p]   = LINK_DOWN;
                    touched     = 1'b1;
                    timeouts_fired++;
                end
                r = pack_view(p);
                r.pack_touched = touched;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_item mk(logic [1:0] k, logic [10:0] id, logic [3:0] len,
                                 logic [63:0] d, logic [2:0] p, logic [31:0] now);
        t_item it;
        it.kind = k;
        it.id   = id;
        it.len  = len;
        it.data = d;
        it.pidx = p;
        it.now  = now;
        return it;
    endfunction

    function automatic t_res plain(bit txv, logic [10:0] txid, bit txl, bit touched,
                                   logic [2:0] pn, t_link ln);
        t_res r;
        r              = '0;
        r.tx_valid     = txv;
        r.tx_id        = txid;
        r.tx_length    = txl;
        r.pack_touched = touched;
        r.pack_number  = pn;
        r.link_state   = ln;
        return r;
    endfunction

    function automatic void add_row(t_item s, bit typed, t_res want);
        t_row row;
        row.s     = s;
        row.typed = typed;
        row.want  = want;
        rows.push_back(row);
    endfunction

    function automatic t_item next_random_item();
        t_item        it;
        logic [127:0] raw;
        int           roll;
        int           pick;
        raw  = {$urandom, $urandom, $urandom, $urandom};
        it   = raw[$bits(t_item)-1:0];
        roll = $urandom_range(99);
        if ($urandom_range(99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 2 * int'(timeout_ms));
        it.now = clock_ms;
        if (roll < 20) begin
            it.kind = KIND_SYNC;
        end else if (roll < 35) begin
            it.kind = KIND_CHECK;
        end else if (roll < 55) begin
            it.kind = KIND_FRAME;
            it.id   = {FN_SDO, 7'($urandom_range(1, NPACK))};
            pick    = $urandom_range(99);
            if (pick < 60)
                it.len = 4'd8;
            else if (pick < 75)
                it.len = 4'($urandom_range(9, 15));
            else
                it.len = 4'($urandom_range(0, 7));
        end else if (roll < 90) begin
            it.kind = KIND_FRAME;
            case ($urandom_range(3))
                0:       it.id[10:7] = FN_PDO1;
                1:       it.id[10:7] = FN_PDO2;
                2:       it.id[10:7] = FN_PDO3;
                default: it.id[10:7] = FN_PDO4;
            endcase
            it.id[6:0] = 7'($urandom_range(1, NPACK));
        end
        return it;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_LINES)
            $display("tb_top: mismatch: %s", msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("report %0d %s got %0h want %0h",
                                   reports_seen, name, got, want));
    endtask

    task automatic check_report();
        t_res got;
        t_res want;
        got.tx_valid       = o_m_axis_tuser[0];
        got.tx_id          = o_m_axis_tdata[10:0];
        got.tx_length      = o_m_axis_tdata[11];
        got.pack_touched   = o_m_axis_tdata[12];
        got.pack_number    = o_m_axis_tdata[15:13];
        got.link_state     = o_m_axis_tdata[17:16];
        got.pack_voltage   = o_m_axis_tdata[37:18];
        got.pack_current   = o_m_axis_tdata[57:38];
        got.charge_percent = o_m_axis_tdata[65:58];
        got.pack_mode      = o_m_axis_tdata[73:66];
        got.status_bits    = o_m_axis_tdata[89:74];
        reports_seen++;
        if (reports_due.size() == 0) begin
            report_error($sformatf("report %0d arrived with nothing outstanding",
                                   reports_seen));
        end else begin
            want = reports_due.pop_front();
            compare_field("tx_valid", got.tx_valid, want.tx_valid);
            compare_field("tx_id", got.tx_id, want.tx_id);
            compare_field("tx_length", got.tx_length, want.tx_length);
            compare_field("pack_touched", got.pack_touched, want.pack_touched);
            compare_field("pack_number", got.pack_number, want.pack_number);
            compare_field("link_state", got.link_state, want.link_state);
            compare_field("pack_voltage", got.pack_voltage, want.pack_voltage);
            compare_field("pack_current", got.pack_current, want.pack_current);
            compare_field("charge_percent", got.charge_percent, want.charge_percent);
            compare_field("pack_mode", got.pack_mode, want.pack_mode);
            compare_field("status_bits", got.status_bits, want.status_bits);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_report();
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_item(t_item it, bit typed, t_res want);
        t_res calc;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= {6'd0, it.now, it.pidx, it.data, it.len, it.id};
        i_s_axis_tuser  <= it.kind;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        calc = track_item(it);
        reports_due.push_back(typed ? want : calc);
        items_sent++;
        if (calc != '0)
            live_items++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        timeout_ms   = v;
        last_timeout = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int target);
        while (live_items < target)
            send_item(next_random_item(), 1'b0, '0);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        hold_left       = 0;
        errors          = 0;
        items_sent      = 0;
        live_items      = 0;
        reports_seen    = 0;
        timeouts_fired  = 0;
        pdo_updates     = 0;
        clock_ms        = 32'd5000;
        snd_idle_pct    = 28;
        rcv_idle_pct    = 56;
        reset_tracker();

        add_row(mk(KIND_CHECK, 11'd0, 4'd0, 64'd0, 3'd0, 32'd0), 1'b1,
                plain(0, 11'd0, 0, 0, 3'd0, LINK_DOWN));
        add_row(mk(KIND_SPARE, 11'h7FF, 4'hF, '1, 3'd7, '1), 1'b1, '0);
        add_row(mk(KIND_FRAME, {FN_PDO1, 7'd0}, 4'd8, '1, 3'd0, 32'd0), 1'b1, '0);
        add_row(mk(KIND_FRAME, {FN_PDO1, 7'd9}, 4'd8, '1, 3'd0, 32'd0), 1'b1, '0);
        add_row(mk(KIND_FRAME, {FN_PDO1, 7'd1}, 4'd8, '1, 3'd0, 32'd0), 1'b1,
                plain(0, 11'd0, 0, 0, 3'd0, LINK_DOWN));
        add_row(mk(KIND_SYNC, 11'd0, 4'd0, 64'd0, 3'd0, 32'd100), 1'b1,
                plain(1, TX_BASE + 11'd1, 0, 1, 3'd0, LINK_AUTH));
        add_row(mk(KIND_SYNC, 11'd0, 4'd0, 64'd0, 3'd0, 32'd200), 1'b1,
                plain(0, 11'd0, 0, 0, 3'd0, LINK_AUTH));
        add_row(mk(KIND_CHECK, 11'd0, 4'd0, 64'd0, 3'd0, 32'd600), 1'b1,
                plain(0, 11'd0, 0, 0, 3'd0, LINK_AUTH));
        add_row(mk(KIND_CHECK, 11'd0, 4'd0, 64'd0, 3'd0, 32'd601), 1'b1,
                plain(0, 11'd0, 0, 1, 3'd0, LINK_DOWN));
        add_row(mk(KIND_SYNC, 11'd0, 4'd0, 64'd0, 3'd7, 32'hFFFF_FF00), 1'b1,
                plain(1, TX_BASE + 11'd8, 0, 1, 3'd7, LINK_AUTH));
        add_row(mk(KIND_CHECK, 11'd0, 4'd0, 64'd0, 3'd7, 32'hFFFF_FFFF), 1'b1,
                plain(0, 11'd0, 0, 1, 3'd7, LINK_DOWN));
        add_row(mk(KIND_SYNC, 11'd0, 4'd0, 64'd0, 3'd1, 32'd1000), 1'b1,
                plain(1, TX_BASE + 11'd2, 0, 1, 3'd1, LINK_AUTH));
        add_row(mk(KIND_FRAME, {FN_SDO, 7'd2}, 4'd8, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b1, plain(0, 11'd0, 0, 1, 3'd1, LINK_AUTH));
        add_row(mk(KIND_FRAME, {FN_SDO, 7'd2}, 4'd15, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b1, plain(0, 11'd0, 0, 1, 3'd1, LINK_AUTH));
        add_row(mk(KIND_FRAME, {FN_SDO, 7'd2}, 4'd3, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b1, plain(0, 11'd0, 0, 1, 3'd1, LINK_UP));
        add_row(mk(KIND_FRAME, {FN_PDO1, 7'd2}, 4'd0, '1, 3'd0, 32'd0), 1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_PDO1, 7'd2}, 4'd8, 64'h0000_0000_8000_0000, 3'd0, 32'd0),
                1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_PDO2, 7'd2}, 4'd8, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_PDO3, 7'd2}, 4'd8, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_PDO4, 7'd2}, 4'd8, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_UNUSED, 7'd2}, 4'd8, '1, 3'd0, 32'd0), 1'b1, '0);
        add_row(mk(KIND_SYNC, 11'd0, 4'd0, 64'd0, 3'd1, 32'd2000), 1'b0, '0);
        add_row(mk(KIND_FRAME, {FN_SDO, 7'd3}, 4'd0, 64'd0, 3'd0, 32'd0), 1'b1,
                plain(0, 11'd0, 0, 1, 3'd2, LINK_UP));
        add_row(mk(KIND_FRAME, 11'h7FF, 4'd8, '1, 3'd0, 32'd0), 1'b1, '0);
        add_row(mk(KIND_FRAME, {FN_SDO, 7'd8}, 4'd8, {$urandom, $urandom}, 3'd0, 32'd0),
                1'b1, plain(0, 11'd0, 0, 1, 3'd7, LINK_AUTH));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_item(rows[i].s, rows[i].typed, rows[i].want);
        drain();

        // sender idles lightly, receiver heavily, shortest deadline
        set_timeout(16'd1);
        run_random(200);
        drain();

        snd_idle_pct = 56;
        rcv_idle_pct = 28;
        set_timeout(16'hFFFF);
        run_random(400);
        drain();

        // no idling, plus a long receiver hold-off at the start to back up the input
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_timeout(16'($urandom_range(2, 400)));
        hold_left = HOLD_CYCLES;
        run_random(600);
        drain();

        if (reports_due.size() != 0)
            report_error($sformatf("%0d reports never arrived", reports_due.size()));

        $display("run: %0d items, %0d reports checked, %0d deadline expiries, %0d PDO updates",
                 items_sent, reports_seen, timeouts_fired, pdo_updates);
        $display("run: reply timeouts 500, 1, 65535 and %0d ms; one %0d-cycle receiver hold-off",
                 last_timeout, HOLD_CYCLES);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
